### rtl/pgu_pkg.sv
// Shared widths, status codes and register indexes for the particle update core.
package pgu_pkg;

   // Field widths of the request and response records.
   localparam int DATA_W    = 32;
   localparam int FT_W      = 16;
   localparam int DIST_W    = 48;
   localparam int CSR_IDX_W = 3;

   // Status reported with every response.
   typedef enum logic [1:0] {
      STATUS_UNUSED = 2'd0,
      STATUS_ALIVE  = 2'd1,
      STATUS_DIED   = 2'd2
   } status_type;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_TIME    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY_ACCEL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_X      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_Y      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_Z      = 3'd4;

endpackage

### rtl/pgu_req_if.sv
// Request channel carrying one particle record.
interface pgu_req_if import pgu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] pos_x_in;
   logic [DATA_W-1:0] pos_y_in;
   logic [DATA_W-1:0] pos_z_in;
   logic [DATA_W-1:0] vel_x_in;
   logic [DATA_W-1:0] vel_y_in;
   logic [DATA_W-1:0] vel_z_in;
   logic [DATA_W-1:0] life_in;

   modport source (
      output valid, pos_x_in, pos_y_in, pos_z_in, vel_x_in, vel_y_in, vel_z_in, life_in,
      input  ready
   );
   modport sink (
      input  valid, pos_x_in, pos_y_in, pos_z_in, vel_x_in, vel_y_in, vel_z_in, life_in,
      output ready
   );
endinterface

### rtl/pgu_rsp_if.sv
// Response channel carrying one updated particle record.
interface pgu_rsp_if import pgu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] pos_x_out;
   logic [DATA_W-1:0] pos_y_out;
   logic [DATA_W-1:0] pos_z_out;
   logic [DATA_W-1:0] vel_x_out;
   logic [DATA_W-1:0] vel_y_out;
   logic [DATA_W-1:0] vel_z_out;
   logic [DATA_W-1:0] life_out;
   logic [DIST_W-1:0] camera_dist_sq;
   status_type        particle_status;

   modport source (
      output valid, pos_x_out, pos_y_out, pos_z_out, vel_x_out, vel_y_out, vel_z_out,
             life_out, camera_dist_sq, particle_status,
      input  ready
   );
   modport sink (
      input  valid, pos_x_out, pos_y_out, pos_z_out, vel_x_out, vel_y_out, vel_z_out,
             life_out, camera_dist_sq, particle_status,
      output ready
   );
endinterface

### rtl/particle_gravity_update_core.sv
// Seven-stage pipelined Euler particle update with gravity and camera distance.
// Throughput: one request per cycle while responses are taken; each stage holds
// its data on a stall and lets bubbles collapse, so requests keep entering while
// a finished response waits. Reset clears all stage valid bits and loads the
// configuration registers with their defaults.
module particle_gravity_update_core import pgu_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   pgu_req_if.sink              req_bus,
   pgu_rsp_if.source            rsp_bus,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   localparam int STAGES     = 7;
   localparam int PROD_W     = DATA_W + FT_W + 1;
   localparam int GRAV_SHIFT = FT_W + 1;
   localparam int DT_W       = FT_W + FRAC_BITS;
   localparam int LIFE_W     = ((DT_W > DATA_W) ? DT_W : DATA_W) + 1;
   localparam int DIFF_W     = DATA_W + 1;
   localparam int SQ_W       = 2 * DIFF_W;
   localparam int SUM_W      = SQ_W + 2;
   localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'({1'b0, {(DATA_W-1){1'b1}}});
   localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);

   typedef struct packed {
      logic [2:0][DATA_W-1:0] pos;
      logic [2:0][DATA_W-1:0] vel;
      logic [DATA_W-1:0]      life;
      status_type             status;
      logic                   alive;
   } rec_type;

   // Clamp a wide signed sum to the 32-bit signed range.
   function automatic logic [DATA_W-1:0] sat_word(input logic signed [PROD_W-1:0] x);
      logic signed [PROD_W-1:0] y;
      y = x;
      if (x > SAT_HI) begin
         y = SAT_HI;
      end else if (x < SAT_LO) begin
         y = SAT_LO;
      end
      return y[DATA_W-1:0];
   endfunction

   // Configuration registers.
   logic        [FT_W-1:0]   frame_time_ff;
   logic signed [DATA_W-1:0] gravity_accel_ff;
   logic signed [DATA_W-1:0] camera_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_time_ff    <= FT_W'(1049);
         gravity_accel_ff <= -DATA_W'(642908);
         camera_ff[0]     <= DATA_W'(0);
         camera_ff[1]     <= DATA_W'(229376);
         camera_ff[2]     <= DATA_W'(655360);
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_FRAME_TIME:    frame_time_ff    <= csr_wdata[FT_W-1:0];
            CSR_GRAVITY_ACCEL: gravity_accel_ff <= csr_wdata;
            CSR_CAMERA_X:      camera_ff[0]     <= csr_wdata;
            CSR_CAMERA_Y:      camera_ff[1]     <= csr_wdata;
            CSR_CAMERA_Z:      camera_ff[2]     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage enables: a stage loads when it is empty or its successor moves on.
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] en;

   always_comb begin
      en[STAGES-1] = !valid_ff[STAGES-1] || rsp_bus.ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   assign valid_in      = {valid_ff[STAGES-2:0], req_bus.valid};
   assign req_bus.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   rec_type rec_ff [STAGES];
   rec_type rec_in [STAGES];

   // Stage 0: life decrement, status, and the gravity times frame time product.
   logic        [DT_W-1:0]   dt_shift;
   logic        [LIFE_W-1:0] life_ext;
   logic        [LIFE_W-1:0] life_dec;
   logic                     life_pos;
   logic                     still_pos;
   logic signed [PROD_W-1:0] gprod_in;
   logic signed [PROD_W-1:0] gprod_ff;

   always_comb begin
      dt_shift  = (DT_W'(frame_time_ff) << FRAC_BITS) >> FT_W;
      life_ext  = {{(LIFE_W-DATA_W){req_bus.life_in[DATA_W-1]}}, req_bus.life_in};
      life_dec  = life_ext - LIFE_W'(dt_shift);
      life_pos  = !req_bus.life_in[DATA_W-1] && (req_bus.life_in != '0);
      still_pos = !life_dec[LIFE_W-1] && (life_dec != '0);
      gprod_in  = gravity_accel_ff * $signed({1'b0, frame_time_ff});

      rec_in[0].pos    = {req_bus.pos_z_in, req_bus.pos_y_in, req_bus.pos_x_in};
      rec_in[0].vel    = {req_bus.vel_z_in, req_bus.vel_y_in, req_bus.vel_x_in};
      rec_in[0].life   = life_pos ? life_dec[DATA_W-1:0] : req_bus.life_in;
      rec_in[0].alive  = life_pos && still_pos;
      if (!life_pos) begin
         rec_in[0].status = STATUS_UNUSED;
      end else if (still_pos) begin
         rec_in[0].status = STATUS_ALIVE;
      end else begin
         rec_in[0].status = STATUS_DIED;
      end
   end

   // Stage 1: vertical velocity of a live particle picks up half a frame of gravity.
   logic signed [PROD_W-1:0] vy_sum;

   always_comb begin
      vy_sum    = PROD_W'($signed(rec_ff[0].vel[1])) + (gprod_ff >>> GRAV_SHIFT);
      rec_in[1] = rec_ff[0];
      if (rec_ff[0].alive) begin
         rec_in[1].vel[1] = sat_word(vy_sum);
      end
   end

   // Stage 2: displacement products velocity times frame time.
   logic signed [PROD_W-1:0] vprod_in [3];
   logic signed [PROD_W-1:0] vprod_ff [3];

   always_comb begin
      rec_in[2] = rec_ff[1];
      for (int k = 0; k < 3; k++) begin
         vprod_in[k] = $signed(rec_ff[1].vel[k]) * $signed({1'b0, frame_time_ff});
      end
   end

   // Stage 3: position advance with saturation for live particles.
   logic signed [PROD_W-1:0] pos_sum [3];

   always_comb begin
      rec_in[3] = rec_ff[2];
      for (int k = 0; k < 3; k++) begin
         pos_sum[k] = PROD_W'($signed(rec_ff[2].pos[k])) + (vprod_ff[k] >>> FT_W);
         if (rec_ff[2].alive) begin
            rec_in[3].pos[k] = sat_word(pos_sum[k]);
         end
      end
   end

   // Stage 4: absolute distance to the camera on each axis.
   logic [DIFF_W-1:0] diff    [3];
   logic [DIFF_W-1:0] dabs_in [3];
   logic [DIFF_W-1:0] dabs_ff [3];

   always_comb begin
      rec_in[4] = rec_ff[3];
      for (int k = 0; k < 3; k++) begin
         diff[k]    = {rec_ff[3].pos[k][DATA_W-1], rec_ff[3].pos[k]}
                    - {camera_ff[k][DATA_W-1], camera_ff[k]};
         dabs_in[k] = diff[k][DIFF_W-1] ? (~diff[k] + DIFF_W'(1)) : diff[k];
      end
   end

   // Stage 5: squares of the axis distances.
   logic [SQ_W-1:0] sq_in [3];
   logic [SQ_W-1:0] sq_ff [3];

   always_comb begin
      rec_in[5] = rec_ff[4];
      for (int k = 0; k < 3; k++) begin
         sq_in[k] = SQ_W'(dabs_ff[k]) * SQ_W'(dabs_ff[k]);
      end
   end

   // Stage 6: sum, drop fraction bits, saturate to distance width; zero if not alive.
   logic [SUM_W-1:0]  sq_sum;
   logic [SUM_W-1:0]  sq_scaled;
   logic [DIST_W-1:0] dist_in;
   logic [DIST_W-1:0] dist_ff;

   always_comb begin
      rec_in[6] = rec_ff[5];
      sq_sum    = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
      sq_scaled = sq_sum >> FRAC_BITS;
      if (!rec_ff[5].alive) begin
         dist_in = '0;
      end else if (|sq_scaled[SUM_W-1:DIST_W]) begin
         dist_in = '1;
      end else begin
         dist_in = sq_scaled[DIST_W-1:0];
      end
   end

   // Stage data registers.
   always_ff @(posedge clock) begin
      for (int i = 0; i < STAGES; i++) begin
         if (en[i]) begin
            rec_ff[i] <= rec_in[i];
         end
      end
      if (en[0]) begin
         gprod_ff <= gprod_in;
      end
      for (int k = 0; k < 3; k++) begin
         if (en[2]) begin
            vprod_ff[k] <= vprod_in[k];
         end
         if (en[4]) begin
            dabs_ff[k] <= dabs_in[k];
         end
         if (en[5]) begin
            sq_ff[k] <= sq_in[k];
         end
      end
      if (en[6]) begin
         dist_ff <= dist_in;
      end
   end

   // Response from the last stage.
   assign rsp_bus.valid           = valid_ff[STAGES-1];
   assign rsp_bus.pos_x_out       = rec_ff[STAGES-1].pos[0];
   assign rsp_bus.pos_y_out       = rec_ff[STAGES-1].pos[1];
   assign rsp_bus.pos_z_out       = rec_ff[STAGES-1].pos[2];
   assign rsp_bus.vel_x_out       = rec_ff[STAGES-1].vel[0];
   assign rsp_bus.vel_y_out       = rec_ff[STAGES-1].vel[1];
   assign rsp_bus.vel_z_out       = rec_ff[STAGES-1].vel[2];
   assign rsp_bus.life_out        = rec_ff[STAGES-1].life;
   assign rsp_bus.camera_dist_sq  = dist_ff;
   assign rsp_bus.particle_status = rec_ff[STAGES-1].status;

endmodule
